FILE: sv/psk_pkg.sv
// Shared constants, types and codes of the priority spread sketch.
package psk_pkg;

  localparam int BITMAP_BITS  = 65536;
  localparam int BM_W         = 16;
  localparam int NUM_BUCKETS  = 1024;
  localparam int BKT_W        = 10;
  localparam int BUCKET_SLOTS = 4;
  localparam int SLOT_W       = 2;
  localparam int FILL_W       = 3;
  localparam int SKETCH_ROWS  = 3;
  localparam int SKETCH_WIDTH = 1024;
  localparam int COL_W        = 10;
  localparam int ROW_W        = 2;
  localparam int SK_DEPTH     = SKETCH_ROWS * SKETCH_WIDTH;
  localparam int SK_AW        = ROW_W + COL_W;
  localparam int EST_W        = 40;
  localparam int ZC_W         = 17;
  localparam int INC_W        = 25;
  localparam int CNT_W        = 32;
  localparam int CLR_W        = 16;
  localparam int PRIO_W       = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BM_SEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BKT_SEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_SEED01 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_SEED2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SGN_SEED01 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SGN_SEED2  = 3'd6;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_E  = 32'he6546b64;
  localparam logic [31:0] MM_C3 = 32'h85ebca6b;
  localparam logic [31:0] MM_C4 = 32'hc2b2ae35;

  typedef enum logic [1:0] {HSEL_BITMAP, HSEL_BUCKET, HSEL_INDEX, HSEL_SIGN} hsel_e;
  typedef enum logic [1:0] {CAP_NONE, CAP_BIT, CAP_BKT, CAP_COL} cap_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] source_label;
    logic [31:0] dest_label;
    logic [15:0] packet_priority;
  } in_item_t;

  typedef struct packed {
    logic [31:0] spread_estimate;
    logic        new_distinct;
    logic        from_bucket;
  } out_item_t;

  typedef struct packed {
    logic [31:0]       label;
    logic [EST_W-1:0]  est;
    logic [PRIO_W-1:0] prio;
  } slot_t;

  typedef slot_t [BUCKET_SLOTS-1:0] slot_row_t;

  typedef struct packed {
    logic             in_load;
    logic             hash_start;
    hsel_e            hsel;
    logic [ROW_W-1:0] row;
    cap_e             cap;
    logic             bm_rd;
    logic             bm_wr;
    logic             zc_dec;
    logic             div_start;
    logic             bkt_rd;
    logic             bkt_wr;
    logic             spill_src;
    logic             spill_slot;
    logic             sk_rd;
    logic             sk_wr;
    logic             med_cap;
    logic             clr_en;
    logic             out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic div_done;
    logic bm_bit;
    logic is_query;
    logic prio_hi;
    logic hit;
    logic has_free;
    logic evict;
    logic clr_last;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: sv/psk_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
interface psk_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/psk_murmur.sv
// Multi-cycle MurmurHash3 unit for one 4-byte key, one multiply per cycle.
module psk_murmur (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] key_i,
  input  logic [31:0] seed_i,
  output logic        done_o,
  output logic [31:0] hash_o
);
  import psk_pkg::*;

  logic [2:0]  ph_q, ph_d;
  logic        done_q, done_d;
  logic [31:0] k_q, k_d, h_q, h_d;
  logic [31:0] kr, h1, h2, h3, t;

  always_comb begin
    ph_d   = ph_q;
    done_d = 1'b0;
    k_d    = k_q;
    h_d    = h_q;
    kr     = {k_q[16:0], k_q[31:17]};
    h1     = h_q ^ k_q;
    h1     = {h1[18:0], h1[31:19]};
    h2     = (h1 << 2) + h1 + MM_E;
    h3     = h2 ^ 32'd4;
    t      = '0;
    if (start_i) begin
      k_d  = key_i * MM_C1;
      h_d  = seed_i;
      ph_d = 3'd1;
    end else begin
      case (ph_q)
        3'd1: begin
          k_d  = kr * MM_C2;
          ph_d = 3'd2;
        end
        3'd2: begin
          h_d  = h3 ^ (h3 >> 16);
          ph_d = 3'd3;
        end
        3'd3: begin
          t    = h_q * MM_C3;
          h_d  = t ^ (t >> 13);
          ph_d = 3'd4;
        end
        3'd4: begin
          t      = h_q * MM_C4;
          h_d    = t ^ (t >> 16);
          ph_d   = 3'd0;
          done_d = 1'b1;
        end
        default: ph_d = 3'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 3'd0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    h_q <= h_d;
  end

  assign done_o = done_q;
  assign hash_o = h_q;
endmodule

FILE: sv/psk_div.sv
// Restoring divider for the Q.8 linear-counting increment, one quotient bit per cycle.
module psk_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [psk_pkg::ZC_W-1:0]     divisor_i,
  output logic                         done_o,
  output logic [psk_pkg::INC_W-1:0]    quot_o
);
  import psk_pkg::*;

  logic [4:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [ZC_W-1:0]  d_q, d_d, rem_q, rem_d;
  logic [INC_W-1:0] q_q, q_d;
  logic [ZC_W:0]    t;
  logic             ge;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    d_d    = d_q;
    rem_d  = rem_q;
    q_d    = q_q;
    t      = {rem_q, (cnt_q == 5'(INC_W - 1))};
    ge     = t >= {1'b0, d_q};
    if (start_i) begin
      d_d    = (divisor_i == '0) ? ZC_W'(1) : divisor_i;
      rem_d  = '0;
      q_d    = '0;
      cnt_d  = 5'(INC_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? ZC_W'(t - {1'b0, d_q}) : ZC_W'(t);
      q_d   = {q_q[INC_W-2:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    rem_q <= rem_d;
    q_q   <= q_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

FILE: sv/psk_datapath.sv
// Datapath: configuration, hash and divide units, bitmap, bucket and sketch memories.
module psk_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [psk_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [psk_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  psk_pkg::in_item_t              in_item_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output psk_pkg::out_item_t             out_item_o,
  input  psk_pkg::ctrl_cmd_t             cmd_i,
  output psk_pkg::dp_status_t            sts_o
);
  import psk_pkg::*;

  logic [PRIO_W-1:0] thr_q;
  logic [31:0]       bm_seed_q, bkt_seed_q, idx_seed2_q, sgn_seed2_q;
  logic [63:0]       idx_seed01_q, sgn_seed01_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= '0;
      bm_seed_q    <= '0;
      bkt_seed_q   <= '0;
      idx_seed01_q <= '0;
      idx_seed2_q  <= '0;
      sgn_seed01_q <= '0;
      sgn_seed2_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_THRESHOLD:  thr_q        <= cfg_data_i[PRIO_W-1:0];
        REG_BM_SEED:    bm_seed_q    <= cfg_data_i[31:0];
        REG_BKT_SEED:   bkt_seed_q   <= cfg_data_i[31:0];
        REG_IDX_SEED01: idx_seed01_q <= cfg_data_i;
        REG_IDX_SEED2:  idx_seed2_q  <= cfg_data_i[31:0];
        REG_SGN_SEED01: sgn_seed01_q <= cfg_data_i;
        REG_SGN_SEED2:  sgn_seed2_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  in_item_t          it_q;
  logic [31:0]       spill_label_q, spill_val_q;
  logic [BM_W-1:0]   bit_q;
  logic [BKT_W-1:0]  bkt_q;
  logic [COL_W-1:0]  col_q;
  logic [31:0]       key, seed, hash;
  logic              hash_done;

  always_comb begin
    key  = spill_label_q;
    seed = '0;
    case (cmd_i.hsel)
      HSEL_BITMAP: begin
        key  = it_q.source_label ^ it_q.dest_label;
        seed = bm_seed_q;
      end
      HSEL_BUCKET: begin
        key  = it_q.source_label;
        seed = bkt_seed_q;
      end
      HSEL_INDEX: begin
        case (cmd_i.row)
          2'd0:    seed = idx_seed01_q[31:0];
          2'd1:    seed = idx_seed01_q[63:32];
          default: seed = idx_seed2_q;
        endcase
      end
      default: begin
        case (cmd_i.row)
          2'd0:    seed = sgn_seed01_q[31:0];
          2'd1:    seed = sgn_seed01_q[63:32];
          default: seed = sgn_seed2_q;
        endcase
      end
    endcase
  end

  psk_murmur u_murmur (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.hash_start),
    .key_i   (key),
    .seed_i  (seed),
    .done_o  (hash_done),
    .hash_o  (hash)
  );

  logic [ZC_W-1:0]  zc_q;
  logic [INC_W-1:0] inc;
  logic             div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zc_q <= ZC_W'(BITMAP_BITS);
    end else if (cmd_i.zc_dec && zc_q != '0) begin
      zc_q <= zc_q - ZC_W'(1);
    end
  end

  psk_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .divisor_i (zc_q),
    .done_o    (div_done),
    .quot_o    (inc)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      it_q <= in_item_i;
    end
    case (cmd_i.cap)
      CAP_BIT: bit_q <= hash[BM_W-1:0];
      CAP_BKT: bkt_q <= hash[BKT_W-1:0];
      CAP_COL: col_q <= hash[COL_W-1:0];
      default: ;
    endcase
  end

  logic [CLR_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_q <= clr_q + CLR_W'(1);
    end
  end

  logic            bm_mem [BITMAP_BITS];
  logic            bm_rd_q;
  logic [BM_W-1:0] bm_wa;

  assign bm_wa = cmd_i.clr_en ? clr_q : bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en || cmd_i.bm_wr) begin
      bm_mem[bm_wa] <= !cmd_i.clr_en;
    end
    if (cmd_i.bm_rd) begin
      bm_rd_q <= bm_mem[bit_q];
    end
  end

  logic [FILL_W-1:0] fill_mem [NUM_BUCKETS];
  slot_row_t         row_mem [NUM_BUCKETS];
  logic [FILL_W-1:0] fill_rd_q, fill_wd;
  slot_row_t         row_rd_q, row_wd;
  logic [BKT_W-1:0]  fill_wa;
  logic              hit, has_free, evict;
  logic [SLOT_W-1:0] hit_idx, min_idx;
  logic [EST_W:0]    est_sum;
  slot_t             new_slot;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
      if (FILL_W'(s) < fill_rd_q && row_rd_q[s].label == it_q.source_label) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(s);
      end
    end
    min_idx = '0;
    for (int s = 1; s < BUCKET_SLOTS; s++) begin
      if (row_rd_q[s].prio < row_rd_q[min_idx].prio) begin
        min_idx = SLOT_W'(s);
      end
    end
    has_free = fill_rd_q < FILL_W'(BUCKET_SLOTS);
    evict    = it_q.packet_priority > row_rd_q[min_idx].prio;
    est_sum  = {1'b0, row_rd_q[hit_idx].est} + (EST_W + 1)'(inc);
    new_slot = '{label: it_q.source_label, est: EST_W'(inc), prio: it_q.packet_priority};
    row_wd   = row_rd_q;
    fill_wd  = fill_rd_q;
    if (hit) begin
      row_wd[hit_idx].est = est_sum[EST_W] ? '1 : est_sum[EST_W-1:0];
    end else if (has_free) begin
      row_wd[fill_rd_q[SLOT_W-1:0]] = new_slot;
      fill_wd = fill_rd_q + FILL_W'(1);
    end else begin
      row_wd[min_idx] = new_slot;
    end
  end

  assign fill_wa = cmd_i.clr_en ? clr_q[BKT_W-1:0] : bkt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en || cmd_i.bkt_wr) begin
      fill_mem[fill_wa] <= cmd_i.clr_en ? '0 : fill_wd;
    end
    if (cmd_i.bkt_wr) begin
      row_mem[bkt_q] <= row_wd;
    end
    if (cmd_i.bkt_rd) begin
      fill_rd_q <= fill_mem[bkt_q];
      row_rd_q  <= row_mem[bkt_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.spill_src) begin
      spill_label_q <= it_q.source_label;
      spill_val_q   <= 32'(inc >> 8);
    end else if (cmd_i.spill_slot) begin
      spill_label_q <= row_rd_q[min_idx].label;
      spill_val_q   <= row_rd_q[min_idx].est[EST_W-1:8];
    end
  end

  logic [CNT_W-1:0] sk_mem [SK_DEPTH];
  logic [CNT_W-1:0] sk_rd_q, sk_wd;
  logic [SK_AW-1:0] sk_a, sk_wa;
  logic             sk_clr;

  assign sk_a   = {cmd_i.row, col_q};
  assign sk_clr = cmd_i.clr_en && clr_q < CLR_W'(SK_DEPTH);
  assign sk_wa  = cmd_i.clr_en ? clr_q[SK_AW-1:0] : sk_a;
  assign sk_wd  = cmd_i.clr_en ? '0 : (hash[0] ? sk_rd_q + spill_val_q : sk_rd_q - spill_val_q);

  always_ff @(posedge clk_i) begin
    if (sk_clr || cmd_i.sk_wr) begin
      sk_mem[sk_wa] <= sk_wd;
    end
    if (cmd_i.sk_rd) begin
      sk_rd_q <= sk_mem[sk_a];
    end
  end

  logic signed [CNT_W-1:0] med_q [SKETCH_ROWS];
  logic signed [CNT_W-1:0] lo, hi, mid;

  always_ff @(posedge clk_i) begin
    if (cmd_i.med_cap) begin
      med_q[cmd_i.row] <= sk_rd_q;
    end
  end

  always_comb begin
    lo  = (med_q[0] < med_q[1]) ? med_q[0] : med_q[1];
    hi  = (med_q[0] < med_q[1]) ? med_q[1] : med_q[0];
    mid = (med_q[2] < lo) ? lo : ((med_q[2] > hi) ? hi : med_q[2]);
    if (mid < 32'sd1) begin
      mid = 32'sd1;
    end
  end

  logic      newd_q, out_valid_q;
  out_item_t out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newd_q <= 1'b0;
    end else if (cmd_i.in_load) begin
      newd_q <= 1'b0;
    end else if (cmd_i.bm_wr) begin
      newd_q <= 1'b1;
    end
  end

  always_comb begin
    out_d = '0;
    if (it_q.operation) begin
      out_d.from_bucket     = hit;
      out_d.spread_estimate = hit ? row_rd_q[hit_idx].est[EST_W-1:8] : mid;
    end else begin
      out_d.new_distinct = newd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign sts_o.hash_done = hash_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.bm_bit    = bm_rd_q;
  assign sts_o.is_query  = it_q.operation;
  assign sts_o.prio_hi   = it_q.packet_priority > thr_q;
  assign sts_o.hit       = hit;
  assign sts_o.has_free  = has_free;
  assign sts_o.evict     = evict;
  assign sts_o.clr_last  = clr_q == '1;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
endmodule

FILE: sv/psk_ctrl.sv
// Controller: sequences clearing, hashing, bitmap, bucket and sketch steps per item.
module psk_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  psk_pkg::dp_status_t  sts_i,
  output psk_pkg::ctrl_cmd_t   cmd_o
);
  import psk_pkg::*;

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_BM_H    = 5'd2;
  localparam logic [4:0] S_BM_HW   = 5'd3;
  localparam logic [4:0] S_BM_RD   = 5'd4;
  localparam logic [4:0] S_BM_CHK  = 5'd5;
  localparam logic [4:0] S_DIV     = 5'd6;
  localparam logic [4:0] S_DIVW    = 5'd7;
  localparam logic [4:0] S_BKT_H   = 5'd8;
  localparam logic [4:0] S_BKT_HW  = 5'd9;
  localparam logic [4:0] S_BKT_RD  = 5'd10;
  localparam logic [4:0] S_BKT_CHK = 5'd11;
  localparam logic [4:0] S_SK_H    = 5'd12;
  localparam logic [4:0] S_SK_HW   = 5'd13;
  localparam logic [4:0] S_SK_RD   = 5'd14;
  localparam logic [4:0] S_SK_USE  = 5'd15;
  localparam logic [4:0] S_SG_H    = 5'd16;
  localparam logic [4:0] S_SG_HW   = 5'd17;
  localparam logic [4:0] S_FIN     = 5'd18;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SKETCH_ROWS - 1);

  logic [4:0]       state_q, state_d;
  logic [ROW_W-1:0] row_q, row_d;

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    cmd_o      = '0;
    cmd_o.row  = row_q;
    cmd_o.hsel = HSEL_BITMAP;
    cmd_o.cap  = CAP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          row_d         = '0;
          state_d       = S_BM_H;
        end
      end
      S_BM_H: begin
        if (sts_i.is_query) begin
          state_d = S_BKT_H;
        end else begin
          cmd_o.hash_start = 1'b1;
          state_d          = S_BM_HW;
        end
      end
      S_BM_HW: begin
        if (sts_i.hash_done) begin
          cmd_o.cap = CAP_BIT;
          state_d   = S_BM_RD;
        end
      end
      S_BM_RD: begin
        cmd_o.bm_rd = 1'b1;
        state_d     = S_BM_CHK;
      end
      S_BM_CHK: begin
        if (sts_i.bm_bit) begin
          state_d = S_FIN;
        end else begin
          cmd_o.bm_wr  = 1'b1;
          cmd_o.zc_dec = 1'b1;
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          if (sts_i.prio_hi) begin
            state_d = S_BKT_H;
          end else begin
            cmd_o.spill_src = 1'b1;
            state_d         = S_SK_H;
          end
        end
      end
      S_BKT_H: begin
        cmd_o.hsel       = HSEL_BUCKET;
        cmd_o.hash_start = 1'b1;
        state_d          = S_BKT_HW;
      end
      S_BKT_HW: begin
        if (sts_i.hash_done) begin
          cmd_o.cap = CAP_BKT;
          state_d   = S_BKT_RD;
        end
      end
      S_BKT_RD: begin
        cmd_o.bkt_rd = 1'b1;
        state_d      = S_BKT_CHK;
      end
      S_BKT_CHK: begin
        if (sts_i.is_query) begin
          if (sts_i.hit) begin
            state_d = S_FIN;
          end else begin
            cmd_o.spill_src = 1'b1;
            state_d         = S_SK_H;
          end
        end else if (sts_i.hit || sts_i.has_free) begin
          cmd_o.bkt_wr = 1'b1;
          state_d      = S_FIN;
        end else if (sts_i.evict) begin
          cmd_o.bkt_wr     = 1'b1;
          cmd_o.spill_slot = 1'b1;
          state_d          = S_SK_H;
        end else begin
          cmd_o.spill_src = 1'b1;
          state_d         = S_SK_H;
        end
      end
      S_SK_H: begin
        cmd_o.hsel       = HSEL_INDEX;
        cmd_o.hash_start = 1'b1;
        state_d          = S_SK_HW;
      end
      S_SK_HW: begin
        if (sts_i.hash_done) begin
          cmd_o.cap = CAP_COL;
          state_d   = S_SK_RD;
        end
      end
      S_SK_RD: begin
        cmd_o.sk_rd = 1'b1;
        state_d     = S_SK_USE;
      end
      S_SK_USE: begin
        if (sts_i.is_query) begin
          cmd_o.med_cap = 1'b1;
          if (row_q == LAST_ROW) begin
            state_d = S_FIN;
          end else begin
            row_d   = row_q + ROW_W'(1);
            state_d = S_SK_H;
          end
        end else begin
          state_d = S_SG_H;
        end
      end
      S_SG_H: begin
        cmd_o.hsel       = HSEL_SIGN;
        cmd_o.hash_start = 1'b1;
        state_d          = S_SG_HW;
      end
      S_SG_HW: begin
        if (sts_i.hash_done) begin
          cmd_o.sk_wr = 1'b1;
          if (row_q == LAST_ROW) begin
            state_d = S_FIN;
          end else begin
            row_d   = row_q + ROW_W'(1);
            state_d = S_SK_H;
          end
        end
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy)
    else $error("result loaded over a pending transfer");
  a_bm_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.bm_wr |-> !sts_i.bm_bit)
    else $error("bitmap written for a bit already set");
  a_div_after_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> $past(cmd_o.zc_dec))
    else $error("divide started without zero count update");
  a_evict_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.bkt_wr && !sts_i.hit && !sts_i.has_free) |-> sts_i.evict)
    else $error("full bucket overwritten without eviction");
endmodule

FILE: sv/priority_spread_sketch_top.sv
// Top level of the priority spread sketch.
// Channels: in_i takes one item per transfer (operation, source_label, dest_label,
// packet_priority); out_o gives exactly one result per item (spread_estimate,
// new_distinct, from_bucket). cfg_we_i writes register cfg_index_i with cfg_data_i.
// One item is in work at a time. Each MurmurHash goes through the
// shared multiply-per-cycle hash unit; the increment comes from the divide unit.
// Steps per item: update with a known bit: bitmap hash and read; update with a
// new bit written to a bucket: bitmap steps, divide, bucket hash, read and write;
// update spilling to the sketch: divide, then 3 rows (each an index hash, a read
// and a sign hash before the write-back), with or without a bucket lookup first.
// Query: bucket hash and read; on a miss, an index hash and read per sketch row.
// The next item is taken in the cycle after its predecessor's result is loaded.
// After reset a clearing pass zeroes the bitmap, the bucket fill counts and
// the sketch counters; in_i.ready stays low meanwhile.
// Results sit in an output register; while the receiver stalls the next item
// is still taken and worked on, and waits only when its own result is ready.
module priority_spread_sketch_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [psk_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [psk_pkg::CFG_DATA_W-1:0] cfg_data_i,
  psk_stream_if.sink                     in_i,
  psk_stream_if.source                   out_o
);
  import psk_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;

  psk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psk_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_i.payload),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.payload),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign in_i.ready = in_ready;
endmodule

FILE: sim/priority_spread_sketch_top_test.sv
// Self-checking testbench of the priority spread sketch: directed and random traffic against a predictor.
module priority_spread_sketch_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psk_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;
  localparam int SETTLE_CYCLES = 200;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  psk_stream_if #(.T(in_item_t))  pkt_if ();
  psk_stream_if #(.T(out_item_t)) est_if ();

  priority_spread_sketch_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (pkt_if.sink),
    .out_o       (est_if.source)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [15:0] thr_q;
  logic [31:0] bm_seed_q, bkt_seed_q, col_seed_q [SKETCH_ROWS], sgn_seed_q [SKETCH_ROWS];
  bit          bitmap_q [BITMAP_BITS];
  int          zeros_q;
  int          fill_q [NUM_BUCKETS];
  logic [31:0] lbl_q [NUM_BUCKETS*BUCKET_SLOTS];
  logic [39:0] est_q [NUM_BUCKETS*BUCKET_SLOTS];
  logic [15:0] pri_q [NUM_BUCKETS*BUCKET_SLOTS];
  logic [31:0] counter_q [SK_DEPTH];

  out_item_t   pending_est [$];
  int          errors = 0;
  int          hold_cycles = 0;
  bit          no_gaps = 1'b0;
  logic [31:0] src_pool [$];

  function automatic logic [31:0] rotl(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] murmur(logic [31:0] key, logic [31:0] seed);
    logic [31:0] h, k;
    k = key * MM_C1;
    k = rotl(k, 15);
    k = k * MM_C2;
    h = seed ^ k;
    h = rotl(h, 13);
    h = h * 32'd5 + MM_E;
    h ^= 32'd4;
    h ^= h >> 16;
    h = h * MM_C3;
    h ^= h >> 13;
    h = h * MM_C4;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic int bucket_of(logic [31:0] src);
    return int'(murmur(src, bkt_seed_q) % NUM_BUCKETS);
  endfunction

  function automatic int col_of(int r, logic [31:0] src);
    return r * SKETCH_WIDTH + int'(murmur(src, col_seed_q[r]) % SKETCH_WIDTH);
  endfunction

  function automatic void spill(logic [31:0] src, logic [31:0] val);
    int p;
    for (int r = 0; r < SKETCH_ROWS; r++) begin
      p = col_of(r, src);
      if (murmur(src, sgn_seed_q[r]) & 32'd1) counter_q[p] = counter_q[p] + val;
      else counter_q[p] = counter_q[p] - val;
    end
  endfunction

  function automatic int slot_hit(int b, logic [31:0] src);
    for (int s = 0; s < fill_q[b]; s++)
      if (lbl_q[b*BUCKET_SLOTS+s] == src) return s;
    return -1;
  endfunction

  function automatic logic [31:0] sketch_median(logic [31:0] src);
    int signed a, b, c, t;
    a = counter_q[col_of(0, src)];
    b = counter_q[col_of(1, src)];
    c = counter_q[col_of(2, src)];
    if (a > b) begin t = a; a = b; b = t; end
    if (b > c) begin t = b; b = c; c = t; end
    if (a > b) begin t = a; a = b; b = t; end
    return (b < 1) ? 32'd1 : 32'(b);
  endfunction

  function automatic out_item_t predict_spread(in_item_t it);
    out_item_t   res;
    int          b, pos, base, m, bit_idx;
    logic [63:0] inc, sum;
    res = '0;
    b = bucket_of(it.source_label);
    pos = slot_hit(b, it.source_label);
    base = b * BUCKET_SLOTS;
    if (it.operation == OP_QUERY) begin
      if (pos >= 0) begin
        res.spread_estimate = est_q[base+pos][39:8];
        res.from_bucket = 1'b1;
      end else begin
        res.spread_estimate = sketch_median(it.source_label);
      end
      return res;
    end
    bit_idx = int'(murmur(it.source_label ^ it.dest_label, bm_seed_q) % BITMAP_BITS);
    if (bitmap_q[bit_idx]) return res;
    bitmap_q[bit_idx] = 1'b1;
    if (zeros_q > 0) zeros_q--;
    res.new_distinct = 1'b1;
    inc = (64'(BITMAP_BITS) << 8) / 64'((zeros_q != 0) ? zeros_q : 1);
    if (it.packet_priority > thr_q) begin
      if (pos >= 0) begin
        sum = 64'(est_q[base+pos]) + inc;
        est_q[base+pos] = (sum > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : sum[39:0];
      end else if (fill_q[b] < BUCKET_SLOTS) begin
        lbl_q[base+fill_q[b]] = it.source_label;
        est_q[base+fill_q[b]] = inc[39:0];
        pri_q[base+fill_q[b]] = it.packet_priority;
        fill_q[b]++;
      end else begin
        m = 0;
        for (int s = 1; s < BUCKET_SLOTS; s++)
          if (pri_q[base+s] < pri_q[base+m]) m = s;
        if (it.packet_priority > pri_q[base+m]) begin
          spill(lbl_q[base+m], est_q[base+m][39:8]);
          lbl_q[base+m] = it.source_label;
          est_q[base+m] = inc[39:0];
          pri_q[base+m] = it.packet_priority;
        end else begin
          spill(it.source_label, inc[39:8]);
        end
      end
    end else begin
      spill(it.source_label, inc[39:8]);
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pkt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pkt_if.valid   <= 1'b1;
    pkt_if.payload <= it;
    do @(posedge clk_i); while (!pkt_if.ready);
    pending_est = {pending_est, predict_spread(it)};
  endtask

  task automatic drain();
    pkt_if.valid <= 1'b0;
    while (pending_est.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_THRESHOLD:  thr_q = val[15:0];
      REG_BM_SEED:    bm_seed_q = val[31:0];
      REG_BKT_SEED:   bkt_seed_q = val[31:0];
      REG_IDX_SEED01: begin col_seed_q[0] = val[31:0]; col_seed_q[1] = val[63:32]; end
      REG_IDX_SEED2:  col_seed_q[2] = val[31:0];
      REG_SGN_SEED01: begin sgn_seed_q[0] = val[31:0]; sgn_seed_q[1] = val[63:32]; end
      REG_SGN_SEED2:  sgn_seed_q[2] = val[31:0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(logic [15:0] thr, logic [63:0] s1, logic [63:0] s2);
    write_reg(REG_THRESHOLD, 64'(thr));
    write_reg(REG_BM_SEED, 64'(s1[31:0]));
    write_reg(REG_BKT_SEED, 64'(s1[63:32]));
    write_reg(REG_IDX_SEED01, s2);
    write_reg(REG_IDX_SEED2, s1 ^ s2);
    write_reg(REG_SGN_SEED01, ~s2);
    write_reg(REG_SGN_SEED2, s2 + s1);
  endtask

  // labels in groups that each share one bucket under the current bucket seed, plus random loners
  task automatic build_pool(int groups, int per_group, int loners);
    logic [31:0] cand;
    int target;
    src_pool.delete();
    for (int g = 0; g < groups; g++) begin
      target = $urandom_range(0, NUM_BUCKETS - 1);
      for (int n = 0; n < per_group; ) begin
        cand = $urandom;
        if (bucket_of(cand) == target) begin
          src_pool = {src_pool, cand};
          n++;
        end
      end
    end
    repeat (loners) begin
      cand = $urandom;
      src_pool = {src_pool, cand};
    end
  endtask

  function automatic in_item_t make_item(logic op, logic [31:0] src, logic [31:0] dst,
                                         logic [15:0] prio);
    in_item_t it;
    it.operation = op;
    it.source_label = src;
    it.dest_label = dst;
    it.packet_priority = prio;
    return it;
  endfunction

  function automatic logic [15:0] pick_prio();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return thr_q;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item();
    logic [31:0] src;
    src = ($urandom_range(0, 9) == 0) ? $urandom
        : src_pool[$urandom_range(0, src_pool.size() - 1)];
    return make_item(($urandom_range(0, 3) == 0) ? OP_QUERY : OP_UPDATE, src, $urandom,
                     pick_prio());
  endfunction

  task automatic test_directed();
    drain();
    write_all_regs(16'h0000, 64'h0, 64'h0);
    send_item(make_item(OP_QUERY, 32'h0, 32'h0, 16'h0));
    send_item(make_item(OP_UPDATE, 32'h0, 32'h0, 16'h0));
    send_item(make_item(OP_UPDATE, 32'h0, 32'h0, 16'h0));
    send_item(make_item(OP_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(make_item(OP_UPDATE, 32'hFFFF_FFFF, 32'h1234_5678, 16'hFFFF));
    send_item(make_item(OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(make_item(OP_QUERY, 32'h0, 32'h0, 16'h0));
    build_pool(1, 6, 0);
    // fill the bucket, update a resident, evict the lowest, then a newcomer too weak to evict
    for (int i = 0; i < 4; i++)
      send_item(make_item(OP_UPDATE, src_pool[i], $urandom, 16'(100 + i)));
    send_item(make_item(OP_UPDATE, src_pool[0], $urandom, 16'd100));
    send_item(make_item(OP_UPDATE, src_pool[4], $urandom, 16'd500));
    send_item(make_item(OP_UPDATE, src_pool[5], $urandom, 16'd50));
    for (int i = 0; i < 6; i++)
      send_item(make_item(OP_QUERY, src_pool[i], 32'h0, 16'h0));
    drain();
  endtask

  task automatic test_unused_index();
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    repeat (5) send_item(random_item());
    drain();
  endtask

  task automatic test_random_phase(logic [15:0] thr, logic [63:0] s1, logic [63:0] s2,
                                   int count);
    write_all_regs(thr, s1, s2);
    build_pool(4, 6, 12);
    no_gaps = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 50) no_gaps = ~no_gaps;
      send_item(random_item());
    end
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    hold_cycles = 3000;
    repeat (30) send_item(random_item());
    no_gaps = 1'b0;
    drain();
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      est_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (no_gaps) begin
      est_if.ready <= 1'b1;
    end else begin
      est_if.ready <= (pick_gap() == 0);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && est_if.valid && est_if.ready) begin
      if (pending_est.size() == 0) begin
        report_mismatch("unexpected result", est_if.payload.spread_estimate, 32'd0);
      end else begin
        want = pending_est.pop_front();
        if (est_if.payload.spread_estimate !== want.spread_estimate)
          report_mismatch("spread_estimate", est_if.payload.spread_estimate,
                          want.spread_estimate);
        if (est_if.payload.new_distinct !== want.new_distinct)
          report_mismatch("new_distinct", 32'(est_if.payload.new_distinct),
                          32'(want.new_distinct));
        if (est_if.payload.from_bucket !== want.from_bucket)
          report_mismatch("from_bucket", 32'(est_if.payload.from_bucket),
                          32'(want.from_bucket));
      end
    end
  end

  initial begin
    pkt_if.valid   = 1'b0;
    pkt_if.payload = '0;
    est_if.ready   = 1'b0;
    thr_q = '0;
    bm_seed_q = '0;
    bkt_seed_q = '0;
    for (int r = 0; r < SKETCH_ROWS; r++) begin
      col_seed_q[r] = '0;
      sgn_seed_q[r] = '0;
    end
    zeros_q = BITMAP_BITS;
    for (int i = 0; i < NUM_BUCKETS; i++) fill_q[i] = 0;
    for (int i = 0; i < SK_DEPTH; i++) counter_q[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_unused_index();
    test_random_phase(16'h0000, {$urandom, $urandom}, {$urandom, $urandom}, 450);
    test_random_phase(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 300);
    test_random_phase(16'd30000, {$urandom, $urandom}, {$urandom, $urandom}, 600);
    test_backpressure();
    test_random_phase(16'(1 << $urandom_range(0, 15)), {$urandom, $urandom},
                      {$urandom, $urandom}, 600);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
sv/psk_pkg.sv
sv/psk_stream_if.sv
sv/psk_murmur.sv
sv/psk_div.sv
sv/psk_datapath.sv
sv/psk_ctrl.sv
sv/priority_spread_sketch_top.sv
sim/priority_spread_sketch_top_test.sv
